>>> hw/rtl/lrubc_pkg.sv
package lrubc_pkg;

  localparam int KIND_W = 2;
  localparam int DEV_W  = 8;
  localparam int SEC_W  = 32;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 8;
  localparam int STS_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PIN     = 2'd2,
    KIND_UNPIN   = 2'd3
  } kind_t;

  typedef enum logic [STS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_COUNT_ERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PICK,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic pick;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic out_taken;
  } sts_t;

endpackage

>>> hw/rtl/lrubc_ctrl.sv
module lrubc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrubc_pkg::sts_t    sts,
  output lrubc_pkg::cmd_t    cmd
);

  lrubc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrubc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      lrubc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lrubc_pkg::ST_SEARCH;
        end
      end
      lrubc_pkg::ST_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = lrubc_pkg::ST_PICK;
      end
      lrubc_pkg::ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = lrubc_pkg::ST_APPLY;
      end
      lrubc_pkg::ST_APPLY: begin
        // result register must be empty or draining this cycle
        if (!sts.out_full || sts.out_taken) begin
          cmd.apply = 1'b1;
          state_nxt = lrubc_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/lrubc_dp.sv
module lrubc_dp #(
  parameter int NUM_SLOTS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lrubc_pkg::cmd_t                    cmd,
  output lrubc_pkg::sts_t                    sts,
  input  logic [lrubc_pkg::KIND_W-1:0]       in_kind,
  input  logic [lrubc_pkg::DEV_W-1:0]        in_device,
  input  logic [lrubc_pkg::SEC_W-1:0]        in_sector,
  input  logic [lrubc_pkg::IDX_W-1:0]        in_slot_index,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [lrubc_pkg::IDX_W-1:0]        out_slot,
  output logic                               out_need_read,
  output logic [lrubc_pkg::CNT_W-1:0]        out_holders,
  output logic [lrubc_pkg::STS_W-1:0]        out_status
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = lrubc_pkg::CNT_W;
  localparam int IDX_W  = lrubc_pkg::IDX_W;

  typedef logic [SLOT_W-1:0] slot_t;

  // request word
  lrubc_pkg::kind_t                kind_r;
  logic [lrubc_pkg::DEV_W-1:0]     dev_r;
  logic [lrubc_pkg::SEC_W-1:0]     sec_r;
  logic [IDX_W-1:0]                idx_r;

  // per-slot state
  logic [lrubc_pkg::DEV_W-1:0]     tag_dev_r [NUM_SLOTS];
  logic [lrubc_pkg::SEC_W-1:0]     tag_sec_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]            tagged_r;
  logic [NUM_SLOTS-1:0]            valid_r;
  logic [CNT_W-1:0]                cnt_r [NUM_SLOTS];
  slot_t                           rank_r [NUM_SLOTS];

  // search and pick results
  logic [NUM_SLOTS-1:0]            hit_vec_r, hit_vec_nxt;
  logic [NUM_SLOTS-1:0]            free_rank_r, free_rank_nxt;
  slot_t                           sel_slot_r, sel_slot_nxt;
  logic                            sel_hit_r, sel_hit_nxt;
  logic                            sel_found_r, sel_found_nxt;

  // result register
  logic                            out_valid_r;
  logic [IDX_W-1:0]                out_slot_r;
  logic                            out_need_r;
  logic [CNT_W-1:0]                out_holders_r;
  lrubc_pkg::status_t              out_status_r;

  // apply stage signals
  logic [CNT_W-1:0]                cur_cnt;
  logic                            cur_valid;
  slot_t                           old_rank;
  logic                            in_range;
  logic                            cnt_wr;
  logic [CNT_W-1:0]                cnt_new;
  logic                            tag_wr;
  logic                            valid_set;
  logic                            do_mru;
  logic [IDX_W-1:0]                res_slot;
  logic                            res_need;
  logic [CNT_W-1:0]                res_holders;
  lrubc_pkg::status_t              res_status;

  slot_t                           low_rank;
  slot_t                           hit_idx;
  slot_t                           vic_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= lrubc_pkg::kind_t'(in_kind);
      dev_r  <= in_device;
      sec_r  <= in_sector;
      idx_r  <= in_slot_index;
    end
  end

  // parallel tag compare, free slots gathered by rank
  always_comb begin
    hit_vec_nxt   = '0;
    free_rank_nxt = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_vec_nxt[i] = tagged_r[i] && (tag_dev_r[i] == dev_r) && (tag_sec_r[i] == sec_r);
      if (cnt_r[i] == '0) begin
        free_rank_nxt[rank_r[i]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_vec_r   <= hit_vec_nxt;
      free_rank_r <= free_rank_nxt;
    end
  end

  // lowest free rank, then the slot holding it
  always_comb begin
    low_rank = '0;
    hit_idx  = '0;
    vic_idx  = '0;
    for (int r = NUM_SLOTS - 1; r >= 0; r--) begin
      if (free_rank_r[r]) begin
        low_rank = slot_t'(r);
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit_vec_r[i]) begin
        hit_idx = hit_idx | slot_t'(i);
      end
      if ((cnt_r[i] == '0) && (rank_r[i] == low_rank)) begin
        vic_idx = vic_idx | slot_t'(i);
      end
    end
    if (kind_r == lrubc_pkg::KIND_GET) begin
      if (|hit_vec_r) begin
        sel_slot_nxt  = hit_idx;
        sel_hit_nxt   = 1'b1;
        sel_found_nxt = 1'b1;
      end else begin
        sel_slot_nxt  = vic_idx;
        sel_hit_nxt   = 1'b0;
        sel_found_nxt = |free_rank_r;
      end
    end else begin
      sel_slot_nxt  = slot_t'(idx_r);
      sel_hit_nxt   = 1'b0;
      sel_found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      sel_slot_r  <= sel_slot_nxt;
      sel_hit_r   <= sel_hit_nxt;
      sel_found_r <= sel_found_nxt;
    end
  end

  // read-modify-write of the selected slot
  always_comb begin
    cur_cnt     = cnt_r[sel_slot_r];
    cur_valid   = valid_r[sel_slot_r];
    old_rank    = rank_r[sel_slot_r];
    in_range    = (32'(idx_r) < NUM_SLOTS);
    cnt_wr      = 1'b0;
    cnt_new     = cur_cnt;
    tag_wr      = 1'b0;
    valid_set   = 1'b0;
    do_mru      = 1'b0;
    res_slot    = idx_r;
    res_need    = 1'b0;
    res_holders = '0;
    res_status  = lrubc_pkg::STATUS_OK;
    unique case (kind_r)
      lrubc_pkg::KIND_GET: begin
        res_slot = IDX_W'(sel_slot_r);
        if (sel_hit_r) begin
          valid_set = 1'b1;
          res_need  = !cur_valid;
          if (cur_cnt == lrubc_pkg::COUNT_MAX) begin
            res_status  = lrubc_pkg::STATUS_COUNT_ERR;
            res_holders = cur_cnt;
          end else begin
            cnt_wr      = 1'b1;
            cnt_new     = cur_cnt + CNT_W'(1);
            res_holders = cnt_new;
          end
        end else if (sel_found_r) begin
          tag_wr      = 1'b1;
          valid_set   = 1'b1;
          cnt_wr      = 1'b1;
          cnt_new     = CNT_W'(1);
          res_need    = 1'b1;
          res_holders = CNT_W'(1);
        end else begin
          res_slot   = '0;
          res_status = lrubc_pkg::STATUS_NO_FREE;
        end
      end
      lrubc_pkg::KIND_PIN: begin
        if (!in_range) begin
          res_status = lrubc_pkg::STATUS_COUNT_ERR;
        end else if (cur_cnt == lrubc_pkg::COUNT_MAX) begin
          res_status  = lrubc_pkg::STATUS_COUNT_ERR;
          res_holders = cur_cnt;
        end else begin
          cnt_wr      = 1'b1;
          cnt_new     = cur_cnt + CNT_W'(1);
          res_holders = cnt_new;
        end
      end
      lrubc_pkg::KIND_RELEASE, lrubc_pkg::KIND_UNPIN: begin
        if (!in_range) begin
          res_status = lrubc_pkg::STATUS_COUNT_ERR;
        end else if (cur_cnt == '0) begin
          res_status = lrubc_pkg::STATUS_COUNT_ERR;
        end else begin
          cnt_wr      = 1'b1;
          cnt_new     = cur_cnt - CNT_W'(1);
          res_holders = cnt_new;
          do_mru      = (kind_r == lrubc_pkg::KIND_RELEASE) && (cur_cnt == CNT_W'(1));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tagged_r <= '0;
      valid_r  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_r[i]  <= '0;
        rank_r[i] <= slot_t'(i);
      end
    end else if (cmd.apply) begin
      if (cnt_wr) begin
        cnt_r[sel_slot_r] <= cnt_new;
      end
      if (tag_wr) begin
        tagged_r[sel_slot_r] <= 1'b1;
      end
      if (valid_set) begin
        valid_r[sel_slot_r] <= 1'b1;
      end
      if (do_mru) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_t'(i) == sel_slot_r) begin
            rank_r[i] <= slot_t'(NUM_SLOTS - 1);
          end else if (rank_r[i] > old_rank) begin
            rank_r[i] <= rank_r[i] - slot_t'(1);
          end
        end
      end
    end
  end

  // tags are only looked at once the slot is marked tagged
  always_ff @(posedge clk) begin
    if (cmd.apply && tag_wr) begin
      tag_dev_r[sel_slot_r] <= dev_r;
      tag_sec_r[sel_slot_r] <= sec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_slot_r    <= res_slot;
      out_need_r    <= res_need;
      out_holders_r <= res_holders;
      out_status_r  <= res_status;
    end
  end

  assign sts.out_full   = out_valid_r;
  assign sts.out_taken  = !out_stall;
  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_need_read  = out_need_r;
  assign out_holders    = out_holders_r;
  assign out_status     = out_status_r;

endmodule

>>> hw/rtl/lru_block_buffer_cache_top.sv
// Buffer cache directory with reference counts and LRU replacement.
// Input channel (in_*): one word per request; in_kind selects get, release,
// pin or unpin. A get looks up (in_device, in_sector); the other kinds
// address the slot given by in_slot_index.
// Result channel (out_*): exactly one word per request, in request order,
// carrying the granted slot, the need-read flag, the count after the
// request and a status code.
// Steps: the request is registered, then tag compare, slot select, and count
// and rank update, which loads the result into the output register. The
// controller walks those steps in turn and takes no new request before the
// last is done; in_stall is low only while it waits.
// A finished result sits in the output register while the next request is
// taken; if out_stall holds the previous result, the update step waits and
// the result word never changes while stalled.
// Reset (rst_n low, synchronous): all slots untagged and not valid, counts
// zero, slot i at recency rank i, no result pending.
module lru_block_buffer_cache_top #(
  parameter int NUM_SLOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lrubc_pkg::KIND_W-1:0] in_kind,
  input  logic [lrubc_pkg::DEV_W-1:0]  in_device,
  input  logic [lrubc_pkg::SEC_W-1:0]  in_sector,
  input  logic [lrubc_pkg::IDX_W-1:0]  in_slot_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrubc_pkg::IDX_W-1:0]  out_slot,
  output logic                         out_need_read,
  output logic [lrubc_pkg::CNT_W-1:0]  out_holders,
  output logic [lrubc_pkg::STS_W-1:0]  out_status
);

  lrubc_pkg::cmd_t cmd;
  lrubc_pkg::sts_t sts;

  lrubc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrubc_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_device     (in_device),
    .in_sector     (in_sector),
    .in_slot_index (in_slot_index),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_slot      (out_slot),
    .out_need_read (out_need_read),
    .out_holders   (out_holders),
    .out_status    (out_status)
  );

endmodule

>>> hw/rtl/lrubc_chk.sv
module lrubc_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lrubc_pkg::IDX_W-1:0]  out_slot,
  input logic                         out_need_read,
  input logic [lrubc_pkg::CNT_W-1:0]  out_holders,
  input logic [lrubc_pkg::STS_W-1:0]  out_status
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_need_read)
      && $stable(out_holders) && $stable(out_status))
    else $error("stalled result word changed");

  // one request at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  a_no_free_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lrubc_pkg::STATUS_NO_FREE) |->
      (out_slot == '0) && !out_need_read && (out_holders == '0))
    else $error("no-free result carries slot data");

  // a read is only needed on a fresh allocation, which holds one reference
  a_need_read_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_need_read |->
      (out_status == lrubc_pkg::STATUS_OK) && (out_holders == 8'd1))
    else $error("need_read without fresh allocation");

endmodule

bind lru_block_buffer_cache_top lrubc_chk u_lrubc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_slot      (out_slot),
  .out_need_read (out_need_read),
  .out_holders   (out_holders),
  .out_status    (out_status)
);
